FILE: hdl/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, character codes and the Morse code table for the text codec.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

   localparam int unsigned MAX_SYMBOLS = 5;
   localparam int unsigned MAX_RESULTS = 6;
   localparam int unsigned CODE_COUNT  = 36;
   localparam int unsigned LETTER_COUNT = 26;

   localparam logic [7:0] ASCII_TAB   = 8'h09;
   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_DASH  = 8'h2D;
   localparam logic [7:0] ASCII_DOT   = 8'h2E;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_X = 8'h78;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   localparam logic       MODE_ENCODE = 1'b0;
   localparam logic       MODE_DECODE = 1'b1;

   // One Morse code: bit i of pat is symbol i, set for a dash.
   typedef struct packed {
      logic [2:0] len;
      logic [4:0] pat;
   } code_type;

   typedef struct packed {
      logic [4:0] pat;
      logic [2:0] len;
      logic       space_mark;
      logic       invalid;
   } token_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] char;
   } emit_type;

   function automatic code_type code_entry(input logic [5:0] idx);
      code_type c;
      case (idx)
         6'd0:  c = '{len: 3'd2, pat: 5'b00010};
         6'd1:  c = '{len: 3'd4, pat: 5'b00001};
         6'd2:  c = '{len: 3'd4, pat: 5'b00101};
         6'd3:  c = '{len: 3'd3, pat: 5'b00001};
         6'd4:  c = '{len: 3'd1, pat: 5'b00000};
         6'd5:  c = '{len: 3'd4, pat: 5'b00100};
         6'd6:  c = '{len: 3'd3, pat: 5'b00011};
         6'd7:  c = '{len: 3'd4, pat: 5'b00000};
         6'd8:  c = '{len: 3'd2, pat: 5'b00000};
         6'd9:  c = '{len: 3'd4, pat: 5'b01110};
         6'd10: c = '{len: 3'd3, pat: 5'b00101};
         6'd11: c = '{len: 3'd4, pat: 5'b00010};
         6'd12: c = '{len: 3'd2, pat: 5'b00011};
         6'd13: c = '{len: 3'd2, pat: 5'b00001};
         6'd14: c = '{len: 3'd3, pat: 5'b00111};
         6'd15: c = '{len: 3'd4, pat: 5'b00110};
         6'd16: c = '{len: 3'd4, pat: 5'b01011};
         6'd17: c = '{len: 3'd3, pat: 5'b00010};
         6'd18: c = '{len: 3'd3, pat: 5'b00000};
         6'd19: c = '{len: 3'd1, pat: 5'b00001};
         6'd20: c = '{len: 3'd3, pat: 5'b00100};
         6'd21: c = '{len: 3'd4, pat: 5'b01000};
         6'd22: c = '{len: 3'd3, pat: 5'b00110};
         6'd23: c = '{len: 3'd4, pat: 5'b01001};
         6'd24: c = '{len: 3'd4, pat: 5'b01101};
         6'd25: c = '{len: 3'd4, pat: 5'b00011};
         6'd26: c = '{len: 3'd5, pat: 5'b11111};
         6'd27: c = '{len: 3'd5, pat: 5'b11110};
         6'd28: c = '{len: 3'd5, pat: 5'b11100};
         6'd29: c = '{len: 3'd5, pat: 5'b11000};
         6'd30: c = '{len: 3'd5, pat: 5'b10000};
         6'd31: c = '{len: 3'd5, pat: 5'b00000};
         6'd32: c = '{len: 3'd5, pat: 5'b00001};
         6'd33: c = '{len: 3'd5, pat: 5'b00011};
         6'd34: c = '{len: 3'd5, pat: 5'b00111};
         6'd35: c = '{len: 3'd5, pat: 5'b01111};
         default: c = '{len: 3'd0, pat: 5'b00000};
      endcase
      return c;
   endfunction

   // Character that a table entry stands for.
   function automatic logic [7:0] entry_char(input logic [5:0] idx);
      logic [7:0] c;
      if (idx < 6'(LETTER_COUNT)) begin
         c = ASCII_LOWER_A + {2'b00, idx};
      end else begin
         c = ASCII_ZERO + {2'b00, idx} - 8'(LETTER_COUNT);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/morse_text_codec_unit.sv
// ----------------------------------------------------------------------------
// morse_text_codec_unit
// ASCII to Morse encoder and Morse to ASCII decoder, one byte per beat.
// ----------------------------------------------------------------------------
//  channel   direction  ports                                  beat
//  req       in         req_valid/req_stall, char_in, eol      one ASCII byte
//  rsp       out        rsp_valid/rsp_stall, char_out, last    one output byte
//  csr       in         csr_wr_en, csr_wr_data                 mode bit
//
//  An input byte is worked out in the cycle it is taken and its results are
//  loaded into a burst buffer; the buffer hands one result per cycle to the
//  single output register while the output is not stalled. A byte has up to
//  6 results when encoding and up to 2 when decoding. Reset clears the mode,
//  the pending token and both buffers. A stalled output holds its byte and
//  the burst buffer; a new byte is taken as soon as the last result of the
//  previous one moves to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_text_codec_unit
   import mtc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_end_of_line,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_last
);

   logic            mode_ff;
   token_type       token_ff, token_in;
   logic [7:0]      burst_ff [MAX_RESULTS];
   logic [7:0]      burst_in [MAX_RESULTS];
   logic [2:0]      burst_cnt_ff, burst_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            out_free, take, accept;

   // Per-item result list
   logic [7:0]      list [MAX_RESULTS];
   logic [2:0]      list_cnt;
   token_type       token_next;

   function automatic emit_type flush(input token_type t);
      emit_type e;
      code_type ce;
      e = '{valid: 1'b0, char: ASCII_SPACE};
      if (!t.invalid) begin
         if (t.space_mark) begin
            e = '{valid: 1'b1, char: ASCII_SPACE};
         end else if (t.len != 3'd0) begin
            for (int i = 0; i < CODE_COUNT; i++) begin
               ce = code_entry(6'(i));
               if (ce.len == t.len && ce.pat == t.pat) begin
                  e = '{valid: 1'b1, char: entry_char(6'(i))};
               end
            end
         end
      end
      return e;
   endfunction

   function automatic token_type add_symbol(input token_type t, input logic [7:0] c);
      token_type r;
      logic      empty;
      r = t;
      empty = (t.len == 3'd0) && !t.space_mark && !t.invalid;
      if (c == ASCII_DOT || c == ASCII_DASH) begin
         if (t.space_mark || t.len >= 3'(MAX_SYMBOLS)) begin
            r.invalid = 1'b1;
         end else begin
            if (c == ASCII_DASH) begin
               r.pat = t.pat | (5'b00001 << t.len);
            end
            r.len = t.len + 3'd1;
         end
      end else if (c == ASCII_LOWER_X && empty) begin
         r.space_mark = 1'b1;
      end else begin
         r.invalid = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      logic [7:0] c;
      logic [5:0] idx;
      logic       is_code;
      logic       is_ws;
      code_type   ce;
      token_type  tok_a;
      emit_type   em0, em1;

      for (int k = 0; k < MAX_RESULTS; k++) begin
         list[k] = ASCII_SPACE;
      end
      list_cnt   = 3'd0;
      token_next = token_ff;
      c          = req_char_in;
      idx        = 6'd0;
      is_code    = 1'b0;
      ce         = '0;
      tok_a      = token_ff;
      em0        = '0;
      em1        = '0;
      is_ws      = (c == ASCII_SPACE) || (c >= ASCII_TAB && c <= ASCII_CR);

      if (mode_ff == MODE_ENCODE) begin
         if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            c = c + CASE_OFFSET;
         end
         if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            idx     = 6'(c - ASCII_LOWER_A);
            is_code = 1'b1;
         end else if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            idx     = 6'(c - ASCII_ZERO) + 6'(LETTER_COUNT);
            is_code = 1'b1;
         end
         ce = code_entry(idx);
         if (is_code) begin
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
               if (3'(k) < ce.len) begin
                  list[k] = ce.pat[k] ? ASCII_DASH : ASCII_DOT;
               end
            end
            list_cnt = ce.len + 3'd1;
         end else if (c == ASCII_SPACE) begin
            list[0]  = ASCII_LOWER_X;
            list_cnt = 3'd2;
         end else begin
            list_cnt = 3'd1;
         end
      end else begin
         if (is_ws) begin
            em0   = flush(token_ff);
            tok_a = '0;
         end else begin
            tok_a = add_symbol(token_ff, c);
         end
         if (req_end_of_line) begin
            em1        = flush(tok_a);
            token_next = '0;
         end else begin
            token_next = tok_a;
         end
         if (em0.valid) begin
            list[list_cnt] = em0.char;
            list_cnt       = list_cnt + 3'd1;
         end
         if (em1.valid) begin
            list[list_cnt] = em1.char;
            list_cnt       = list_cnt + 3'd1;
         end
         if (req_end_of_line) begin
            list[list_cnt] = ASCII_LF;
            list_cnt       = list_cnt + 3'd1;
         end
      end
   end

   // Handshake: take a new byte once the burst is empty or about to drain.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take      = (burst_cnt_ff != 3'd0) && out_free;
   assign req_stall = !((burst_cnt_ff == 3'd0) || (burst_cnt_ff == 3'd1 && out_free));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      burst_in     = burst_ff;
      burst_cnt_in = burst_cnt_ff;
      token_in     = token_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = burst_ff[0];
         rsp_last_in  = (burst_cnt_ff == 3'd1);
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         burst_in     = list;
         burst_cnt_in = list_cnt;
         if (mode_ff == MODE_DECODE) begin
            token_in = token_next;
         end
      end else if (take) begin
         // advance the burst by one
         for (int k = 0; k < MAX_RESULTS - 1; k++) begin
            burst_in[k] = burst_ff[k + 1];
         end
         burst_cnt_in = burst_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ENCODE;
         token_ff     <= '0;
         burst_cnt_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         token_ff     <= token_in;
         burst_cnt_ff <= burst_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff    <= burst_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // A burst never holds more than six results.
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      burst_cnt_ff <= 3'(MAX_RESULTS))
      else $error("burst count out of range");

   // A token is never longer than five symbols.
   a_token_len: assert property (@(posedge clock) disable iff (reset)
      token_ff.len <= 3'(MAX_SYMBOLS))
      else $error("token length out of range");

   // A space mark carries no symbols.
   a_space_mark: assert property (@(posedge clock) disable iff (reset)
      token_ff.space_mark |-> token_ff.len == 3'd0)
      else $error("space mark with symbols");

   // No pattern bit beyond the token length.
   a_token_pat: assert property (@(posedge clock) disable iff (reset)
      (token_ff.pat >> token_ff.len) == 5'd0)
      else $error("stray pattern bit");

   // A beat that is not the last of its byte is followed by another.
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("burst broken before last beat");

endmodule

`default_nettype wire
